@@ hw/rtl/wcht_pkg.sv @@
// ----------------------------------------------------------------------------
// wcht_pkg
// Shared types, codes and constants for the word count hash table.
// ----------------------------------------------------------------------------
package wcht_pkg;

    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int MAX_WORD_DEF    = 32;

    localparam int COUNT_W = 24;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_FULL      = 3'd3,
        ST_SLOT_READ = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_LONG,
        S_FULL,
        S_SLOT
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [11:0] read_slot;
        logic [4:0]  read_pos;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] slot;
        logic [23:0] word_count;
        logic [5:0]  word_length;
        logic [63:0] word_hash;
        logic [7:0]  stored_byte;
        logic [12:0] unique_words;
    } t_out_item;

    // fnv-1 step: prime is 2^40 + 2^8 + 0xb3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] low_prod;
        low_prod = h * 8'hB3;
        return ((h << 40) + (h << 8) + low_prod) ^ {56'd0, b};
    endfunction

endpackage

@@ hw/rtl/word_count_hash_table.sv @@
// ----------------------------------------------------------------------------
// word_count_hash_table
// Tokenizes a byte stream into words, hashes them with fnv-1 and counts them
// in an open-addressing table with linear probing.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes text bytes,
//   end-of-input marks and slot reads; output channel (o_out_valid /
//   i_out_ready / o_out_data) returns one result per finished word or read.
//   a word byte yields no result. a finished word probes the table with one
//   read-compare pass per slot, a read in S_LOOK and a compare in S_CHECK.
//   the probe loop over the single table memory sets the rate.
//   after reset the table is cleared one slot per cycle, with o_in_ready
//   low. results sit in an output register: text bytes are still taken while
//   it is held, and a word or read waits in its final state until the
//   register is free.
// ----------------------------------------------------------------------------
module word_count_hash_table #(
    parameter int TABLE_SLOTS = wcht_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_WORD    = wcht_pkg::MAX_WORD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wcht_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wcht_pkg::t_out_item o_out_data
);

    import wcht_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int LEN_W  = $clog2(MAX_WORD + 2);
    localparam int IDX_W  = $clog2(MAX_WORD);
    localparam int WORD_W = MAX_WORD * 8;
    localparam int UNIQ_W = $clog2(TABLE_SLOTS + 1);
    localparam int ROW_W  = LEN_W + COUNT_W + WORD_W;

    t_state r_state, n_state;

    logic [SLOT_W-1:0]          r_clr, n_clr;
    logic [LEN_W-1:0]           r_len, n_len;
    logic [63:0]                r_hash, n_hash;
    logic [MAX_WORD-1:0][7:0]   r_buf, n_buf;
    logic [LEN_W-1:0]           r_wlen, n_wlen;
    logic [63:0]                r_whash, n_whash;
    logic [SLOT_W-1:0]          r_probe, n_probe;
    logic [SLOT_W-1:0]          r_tries, n_tries;
    logic [4:0]                 r_pos, n_pos;
    logic [UNIQ_W-1:0]          r_uniq, n_uniq;
    logic                       r_out_valid, n_out_valid;
    t_out_item                  r_out, n_out;

    logic                       ram_we, ram_re;
    logic [SLOT_W-1:0]          ram_waddr, ram_raddr;
    logic [ROW_W-1:0]           ram_wdata, ram_rdata;

    logic [LEN_W-1:0]           rd_len;
    logic [COUNT_W-1:0]         rd_cnt, inc_cnt;
    logic [MAX_WORD-1:0][7:0]   rd_word;
    logic [MAX_WORD-1:0]        byte_eq;
    logic                       word_match;
    logic                       pos_ok;
    logic [7:0]                 rd_byte;

    logic                       in_acc, out_free, is_sep, word_end;
    logic                       last_try;
    logic [7:0]                 low_byte;
    logic [SLOT_W-1:0]          home;

    wcht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign is_sep   = (i_in_data.data_byte <= 8'h20) || (i_in_data.data_byte >= 8'h80);
    assign word_end = ((i_in_data.kind == KIND_BYTE) && is_sep) || (i_in_data.kind == KIND_END);
    assign low_byte = ((i_in_data.data_byte >= 8'h41) && (i_in_data.data_byte <= 8'h5A))
                    ? (i_in_data.data_byte | 8'h20) : i_in_data.data_byte;

    assign home     = r_whash[SLOT_W-1:0];
    assign last_try = (r_tries == SLOT_W'(TABLE_SLOTS - 1));

    // row layout: length, count, word bytes
    assign rd_len  = ram_rdata[ROW_W-1 -: LEN_W];
    assign rd_cnt  = ram_rdata[WORD_W +: COUNT_W];
    assign rd_word = ram_rdata[WORD_W-1:0];
    assign inc_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

    always_comb begin
        for (int i = 0; i < MAX_WORD; i++) begin
            byte_eq[i] = (LEN_W'(i) >= r_wlen) || (rd_word[i] == r_buf[i]);
        end
    end

    assign word_match = (rd_len == r_wlen) && (&byte_eq);
    assign pos_ok     = (8'(r_pos) < 8'(rd_len));
    assign rd_byte    = pos_ok ? rd_word[IDX_W'(r_pos)] : 8'd0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == KIND_READ) begin
                        n_state = S_SLOT;
                    end else if (word_end && (r_len != '0)) begin
                        n_state = (r_len > LEN_W'(MAX_WORD)) ? S_LONG : S_LOOK;
                    end
                end
            end
            S_LOOK: n_state = S_CHECK;
            S_CHECK: begin
                if ((rd_len == '0) || word_match) begin
                    if (out_free) n_state = S_IDLE;
                end else begin
                    n_state = last_try ? S_FULL : S_LOOK;
                end
            end
            S_LONG, S_FULL, S_SLOT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic load;
        load      = 1'b0;
        n_clr     = r_clr;
        n_len     = r_len;
        n_hash    = r_hash;
        n_buf     = r_buf;
        n_wlen    = r_wlen;
        n_whash   = r_whash;
        n_probe   = r_probe;
        n_tries   = r_tries;
        n_pos     = r_pos;
        n_uniq    = r_uniq;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_probe;
        ram_wdata = {r_wlen, COUNT_W'(1), r_buf};
        ram_re    = 1'b0;
        ram_raddr = r_probe;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == KIND_READ) begin
                        ram_re    = 1'b1;
                        ram_raddr = SLOT_W'(i_in_data.read_slot);
                        n_probe   = SLOT_W'(i_in_data.read_slot);
                        n_pos     = i_in_data.read_pos;
                    end else if (word_end) begin
                        n_len   = '0;
                        n_hash  = FNV_BASIS;
                        n_whash = r_hash;
                        n_wlen  = r_len;
                        n_probe = r_hash[SLOT_W-1:0];
                        n_tries = '0;
                    end else if (i_in_data.kind == KIND_BYTE) begin
                        n_hash = fnv_step(r_hash, low_byte);
                        if (r_len < LEN_W'(MAX_WORD)) n_buf[IDX_W'(r_len)] = low_byte;
                        if (r_len <= LEN_W'(MAX_WORD)) n_len = r_len + 1'b1;
                    end
                end
            end
            S_LOOK: begin
                ram_re = 1'b1;
            end
            S_CHECK: begin
                if (rd_len == '0) begin
                    if (out_free) begin
                        load                = 1'b1;
                        ram_we              = 1'b1;
                        n_uniq              = r_uniq + 1'b1;
                        n_out.status        = ST_INSERTED;
                        n_out.slot          = 12'(r_probe);
                        n_out.word_count    = 24'd1;
                        n_out.word_length   = 6'(r_wlen);
                        n_out.word_hash     = r_whash;
                        n_out.stored_byte   = 8'd0;
                        n_out.unique_words  = 13'(r_uniq + 1'b1);
                    end
                end else if (word_match) begin
                    if (out_free) begin
                        load                = 1'b1;
                        ram_we              = 1'b1;
                        ram_wdata           = {r_wlen, inc_cnt, r_buf};
                        n_out.status        = ST_COUNTED;
                        n_out.slot          = 12'(r_probe);
                        n_out.word_count    = 24'(inc_cnt);
                        n_out.word_length   = 6'(r_wlen);
                        n_out.word_hash     = r_whash;
                        n_out.stored_byte   = 8'd0;
                        n_out.unique_words  = 13'(r_uniq);
                    end
                end else begin
                    // slot holds another word, move on with wrap-around
                    n_probe = r_probe + 1'b1;
                    n_tries = r_tries + 1'b1;
                end
            end
            S_LONG: begin
                if (out_free) begin
                    load               = 1'b1;
                    n_out.status       = ST_TOO_LONG;
                    n_out.slot         = 12'(home);
                    n_out.word_count   = '0;
                    n_out.word_length  = '0;
                    n_out.word_hash    = r_whash;
                    n_out.stored_byte  = '0;
                    n_out.unique_words = 13'(r_uniq);
                end
            end
            S_FULL: begin
                if (out_free) begin
                    load               = 1'b1;
                    n_out.status       = ST_FULL;
                    n_out.slot         = 12'(home);
                    n_out.word_count   = '0;
                    n_out.word_length  = 6'(r_wlen);
                    n_out.word_hash    = r_whash;
                    n_out.stored_byte  = '0;
                    n_out.unique_words = 13'(r_uniq);
                end
            end
            S_SLOT: begin
                if (out_free) begin
                    load               = 1'b1;
                    n_out.status       = ST_SLOT_READ;
                    n_out.slot         = 12'(r_probe);
                    n_out.word_count   = (rd_len != '0) ? 24'(rd_cnt) : 24'd0;
                    n_out.word_length  = 6'(rd_len);
                    n_out.word_hash    = '0;
                    n_out.stored_byte  = rd_byte;
                    n_out.unique_words = 13'(r_uniq);
                end
            end
            default: ;
        endcase

        n_out_valid = load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_len       <= '0;
            r_hash      <= FNV_BASIS;
            r_uniq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_len       <= n_len;
            r_hash      <= n_hash;
            r_uniq      <= n_uniq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf   <= n_buf;
        r_wlen  <= n_wlen;
        r_whash <= n_whash;
        r_probe <= n_probe;
        r_tries <= n_tries;
        r_pos   <= n_pos;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/wcht_ram.sv @@
// ----------------------------------------------------------------------------
// wcht_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
